@@ rtl/core/fdnhr_pkg.sv @@
`timescale 1ns / 1ps
package fdnhr_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int FRAC_W      = SAMPLE_W - 1;
  localparam int NUM_LINES   = 8;
  localparam int LINE_IDX_W  = 3;
  localparam int STORE_DEPTH = 14456;
  localparam int ADDR_W      = 14;
  localparam int POS_W       = 12;
  localparam int MUL_W       = 27;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 56;
  localparam int HAD_W       = 27;
  localparam int DIV_W       = 30;
  localparam int DEN_W       = 29;
  localparam int QUO_W       = 25;

  localparam int HAD_NORM_Q16 = 23170;
  localparam int DC_POLE_Q16  = 65503;

  localparam logic [1:0] CFG_FEEDBACK = 2'd0;
  localparam logic [1:0] CFG_DAMPING  = 2'd1;
  localparam logic [1:0] CFG_WET      = 2'd2;
  localparam logic [1:0] CFG_GAINS    = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [HAD_W-1:0]    had_t;

  function automatic logic [ADDR_W-1:0] line_base(input logic [LINE_IDX_W-1:0] i);
    case (i)
      3'd0:    line_base = ADDR_W'(0);
      3'd1:    line_base = ADDR_W'(1087);
      3'd2:    line_base = ADDR_W'(2370);
      3'd3:    line_base = ADDR_W'(3851);
      3'd4:    line_base = ADDR_W'(5550);
      3'd5:    line_base = ADDR_W'(7457);
      3'd6:    line_base = ADDR_W'(9588);
      default: line_base = ADDR_W'(11899);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] line_last(input logic [LINE_IDX_W-1:0] i);
    case (i)
      3'd0:    line_last = POS_W'(1086);
      3'd1:    line_last = POS_W'(1282);
      3'd2:    line_last = POS_W'(1480);
      3'd3:    line_last = POS_W'(1698);
      3'd4:    line_last = POS_W'(1906);
      3'd5:    line_last = POS_W'(2130);
      3'd6:    line_last = POS_W'(2310);
      default: line_last = POS_W'(2556);
    endcase
  endfunction

  // add half an lsb, then arithmetic shift
  function automatic acc_t round_shift(input acc_t v, input int s);
    round_shift = (v + (acc_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic sample_t sat_sample(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = (acc_t'(1) <<< FRAC_W) - acc_t'(1);
    lo = -(acc_t'(1) <<< FRAC_W);
    if (v > hi) sat_sample = SAMPLE_W'(hi);
    else if (v < lo) sat_sample = SAMPLE_W'(lo);
    else sat_sample = SAMPLE_W'(v);
  endfunction

endpackage

@@ rtl/core/fdn_hadamard_reverb_top.sv @@
`timescale 1ns / 1ps
// channel  | signals                         | dir | meaning
// in       | in_valid in_ready dry_sample    | in  | one dry sample, Q1.23
// out      | out_valid out_ready mixed_sample| out | dry/wet mixed sample, Q1.23
// cfg      | cfg_we cfg_index cfg_data       | in  | register write, no read-back
//
// a new dry sample is taken only after the previous one is finished: 8 delay
// reads, 3 butterfly passes and 8 normalize multiplies, then per line feedback,
// damping and a soft clip whose restoring divider forms a 25-bit quotient, then
// wet sum, blocker and mix; one shared 27x27 multiplier sets the pace. after
// reset a clearing pass zeroes the 14456-entry delay ram with in_ready low. a
// finished sample waits in the output register; the next transaction is taken
// meanwhile and stalls only at its end.
module fdn_hadamard_reverb_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] dry_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] mixed_sample,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_RDC   = 5'd3;
  localparam logic [4:0] S_BF    = 5'd4;
  localparam logic [4:0] S_NM    = 5'd5;
  localparam logic [4:0] S_NMC   = 5'd6;
  localparam logic [4:0] S_FB    = 5'd7;
  localparam logic [4:0] S_FBC   = 5'd8;
  localparam logic [4:0] S_DM    = 5'd9;
  localparam logic [4:0] S_DMC   = 5'd10;
  localparam logic [4:0] S_SQ    = 5'd11;
  localparam logic [4:0] S_SQC   = 5'd12;
  localparam logic [4:0] S_DV    = 5'd13;
  localparam logic [4:0] S_CL    = 5'd14;
  localparam logic [4:0] S_CLC   = 5'd15;
  localparam logic [4:0] S_GN    = 5'd16;
  localparam logic [4:0] S_GNC   = 5'd17;
  localparam logic [4:0] S_WET   = 5'd18;
  localparam logic [4:0] S_BL    = 5'd19;
  localparam logic [4:0] S_BLC   = 5'd20;
  localparam logic [4:0] S_MX1   = 5'd21;
  localparam logic [4:0] S_MX1C  = 5'd22;
  localparam logic [4:0] S_MX2   = 5'd23;
  localparam logic [4:0] S_MX2C  = 5'd24;
  localparam logic [4:0] S_DONE  = 5'd25;

  localparam int CLIP_K = 27 * (2 ** fdnhr_pkg::FRAC_W);

  logic [4:0] state;

  // configuration
  logic [15:0] feedback_gain;
  logic [15:0] damping_coeff;
  logic [15:0] wet_mix;
  logic [63:0] line_gains;

  // per-line state
  logic [fdnhr_pkg::POS_W-1:0] pos [fdnhr_pkg::NUM_LINES];
  fdnhr_pkg::sample_t          damp [fdnhr_pkg::NUM_LINES];
  fdnhr_pkg::sample_t          blk_last;
  fdnhr_pkg::sample_t          blk_out;

  // working registers
  fdnhr_pkg::had_t             h [fdnhr_pkg::NUM_LINES];
  fdnhr_pkg::had_t             bf [fdnhr_pkg::NUM_LINES];
  fdnhr_pkg::sample_t          dry;
  fdnhr_pkg::sample_t          xs;
  fdnhr_pkg::sample_t          wet;
  fdnhr_pkg::sample_t          res;
  logic signed [25:0]          tmp;
  fdnhr_pkg::acc_t             mix_acc;
  logic [fdnhr_pkg::LINE_IDX_W-1:0] li;
  logic [1:0]                  bstage;
  logic [fdnhr_pkg::ADDR_W-1:0] clr;

  // divider
  logic [fdnhr_pkg::DIV_W-1:0] rem;
  logic [fdnhr_pkg::DEN_W-1:0] den;
  logic [fdnhr_pkg::QUO_W-1:0] quo;
  logic [4:0]                  dcnt;
  logic                        dge;

  // shared multiplier
  logic signed [fdnhr_pkg::MUL_W-1:0]  mul_a;
  logic signed [fdnhr_pkg::MUL_W-1:0]  mul_b;
  logic signed [fdnhr_pkg::PROD_W-1:0] mul_p;
  fdnhr_pkg::acc_t                     prod;

  // ram
  logic                          ram_we;
  logic [fdnhr_pkg::ADDR_W-1:0]  ram_waddr;
  logic [fdnhr_pkg::ADDR_W-1:0]  ram_raddr;
  logic [fdnhr_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [fdnhr_pkg::SAMPLE_W-1:0] ram_rdata;
  fdnhr_pkg::sample_t            w_sample;
  logic signed [29:0]            wet_sum;
  logic signed [7:0]             gain;

  assign prod      = fdnhr_pkg::ACC_W'(mul_p);
  assign in_ready  = (state == S_IDLE);
  assign ram_raddr = fdnhr_pkg::line_base(li) + fdnhr_pkg::ADDR_W'(pos[li]);
  assign gain      = $signed(line_gains[{li, 3'b000} +: 8]);
  assign dge       = (rem >= {1'b0, den});
  assign w_sample  = fdnhr_pkg::sat_sample(fdnhr_pkg::round_shift(prod, 7)
                     + fdnhr_pkg::ACC_W'(tmp));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_GNC) begin
      ram_we    = 1'b1;
      ram_waddr = ram_raddr;
      ram_wdata = w_sample;
    end
  end

  fdnhr_ram #(
    .WIDTH(fdnhr_pkg::SAMPLE_W),
    .DEPTH(fdnhr_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // one butterfly pass, stride picked by bstage
  always_comb begin
    int stride;
    stride = 1 << bstage;
    bf = h;
    for (int i = 0; i < fdnhr_pkg::NUM_LINES; i++) begin
      if ((i & stride) == 0) begin
        bf[i]          = h[i] + h[i + stride];
        bf[i + stride] = h[i] - h[i + stride];
      end
    end
  end

  // alternating-sign sum for the wet path
  always_comb begin
    wet_sum = '0;
    for (int i = 0; i < fdnhr_pkg::NUM_LINES; i++) begin
      if (i % 2 == 1) wet_sum = wet_sum - 30'(h[i]);
      else wet_sum = wet_sum + 30'(h[i]);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_NM: begin
        mul_a = h[li];
        mul_b = fdnhr_pkg::MUL_W'(fdnhr_pkg::HAD_NORM_Q16);
      end
      S_FB: begin
        mul_a = h[li];
        mul_b = fdnhr_pkg::MUL_W'($signed({1'b0, feedback_gain}));
      end
      S_DM: begin
        mul_a = fdnhr_pkg::MUL_W'(tmp);
        mul_b = fdnhr_pkg::MUL_W'($signed({1'b0, damping_coeff}));
      end
      S_SQ: begin
        mul_a = fdnhr_pkg::MUL_W'(xs);
        mul_b = fdnhr_pkg::MUL_W'(xs);
      end
      S_CL: begin
        mul_a = fdnhr_pkg::MUL_W'(xs);
        mul_b = fdnhr_pkg::MUL_W'($signed({1'b0, quo}));
      end
      S_GN: begin
        mul_a = fdnhr_pkg::MUL_W'(dry);
        mul_b = fdnhr_pkg::MUL_W'(gain);
      end
      S_BL: begin
        mul_a = fdnhr_pkg::MUL_W'(blk_out) + fdnhr_pkg::MUL_W'(wet)
                - fdnhr_pkg::MUL_W'(blk_last);
        mul_b = fdnhr_pkg::MUL_W'(fdnhr_pkg::DC_POLE_Q16);
      end
      S_MX1: begin
        mul_a = fdnhr_pkg::MUL_W'(dry);
        mul_b = fdnhr_pkg::MUL_W'(65536) - fdnhr_pkg::MUL_W'($signed({1'b0, wet_mix}));
      end
      S_MX2: begin
        mul_a = fdnhr_pkg::MUL_W'(blk_out);
        mul_b = fdnhr_pkg::MUL_W'($signed({1'b0, wet_mix}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // configuration writes, taken in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= 16'd37683;
      damping_coeff <= 16'd32768;
      wet_mix       <= 16'd32768;
      line_gains    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fdnhr_pkg::CFG_FEEDBACK: feedback_gain <= cfg_data[15:0];
        fdnhr_pkg::CFG_DAMPING:  damping_coeff <= cfg_data[15:0];
        fdnhr_pkg::CFG_WET:      wet_mix       <= cfg_data[15:0];
        fdnhr_pkg::CFG_GAINS:    line_gains    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      li        <= '0;
      bstage    <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
      blk_last  <= '0;
      blk_out   <= '0;
      for (int i = 0; i < fdnhr_pkg::NUM_LINES; i++) begin
        pos[i]  <= '0;
        damp[i] <= '0;
      end
    end else begin
      // in the done state the output register is handled below
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == fdnhr_pkg::ADDR_W'(fdnhr_pkg::STORE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            dry   <= $signed(dry_sample);
            li    <= '0;
            state <= S_RD;
          end
        end
        S_RD: state <= S_RDC;
        S_RDC: begin
          h[li] <= fdnhr_pkg::HAD_W'($signed(ram_rdata));
          li    <= li + 1'b1;
          if (li == 3'd7) begin
            bstage <= '0;
            state  <= S_BF;
          end else begin
            state <= S_RD;
          end
        end
        S_BF: begin
          h      <= bf;
          bstage <= bstage + 1'b1;
          if (bstage == 2'd2) state <= S_NM;
        end
        S_NM: state <= S_NMC;
        S_NMC: begin
          h[li] <= fdnhr_pkg::HAD_W'(fdnhr_pkg::sat_sample(
                   fdnhr_pkg::round_shift(prod, 16)));
          li    <= li + 1'b1;
          state <= (li == 3'd7) ? S_FB : S_NM;
        end
        S_FB: state <= S_FBC;
        S_FBC: begin
          tmp   <= 26'(fdnhr_pkg::round_shift(prod, 16)) - 26'(damp[li]);
          state <= S_DM;
        end
        S_DM: state <= S_DMC;
        S_DMC: begin
          damp[li] <= fdnhr_pkg::sat_sample(fdnhr_pkg::ACC_W'(damp[li])
                      + fdnhr_pkg::round_shift(prod, 16));
          xs       <= fdnhr_pkg::sat_sample(fdnhr_pkg::ACC_W'(damp[li])
                      + fdnhr_pkg::round_shift(prod, 16));
          state    <= S_SQ;
        end
        S_SQ: state <= S_SQC;
        S_SQC: begin
          // x2 = x*x >> frac, clip ratio numerator and denominator
          rem   <= fdnhr_pkg::DIV_W'(CLIP_K) + fdnhr_pkg::DIV_W'(prod >>> fdnhr_pkg::FRAC_W);
          den   <= fdnhr_pkg::DEN_W'(CLIP_K)
                   + fdnhr_pkg::DEN_W'(9 * (prod >>> fdnhr_pkg::FRAC_W));
          quo   <= '0;
          dcnt  <= '0;
          state <= S_DV;
        end
        S_DV: begin
          // restoring division, one quotient bit per cycle
          quo  <= {quo[fdnhr_pkg::QUO_W-2:0], dge};
          rem  <= (dge ? rem - fdnhr_pkg::DIV_W'(den) : rem) << 1;
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'(fdnhr_pkg::QUO_W - 1)) state <= S_CL;
        end
        S_CL: state <= S_CLC;
        S_CLC: begin
          tmp   <= 26'(fdnhr_pkg::sat_sample(fdnhr_pkg::round_shift(prod, 24)));
          state <= S_GN;
        end
        S_GN: state <= S_GNC;
        S_GNC: begin
          pos[li] <= (pos[li] == fdnhr_pkg::line_last(li)) ? '0 : pos[li] + 1'b1;
          li      <= li + 1'b1;
          state   <= (li == 3'd7) ? S_WET : S_FB;
        end
        S_WET: begin
          wet   <= fdnhr_pkg::sat_sample(fdnhr_pkg::round_shift(
                   fdnhr_pkg::ACC_W'(wet_sum), 2));
          state <= S_BL;
        end
        S_BL: state <= S_BLC;
        S_BLC: begin
          blk_out  <= fdnhr_pkg::sat_sample(fdnhr_pkg::round_shift(prod, 16));
          blk_last <= wet;
          state    <= S_MX1;
        end
        S_MX1: state <= S_MX1C;
        S_MX1C: begin
          mix_acc <= prod;
          state   <= S_MX2;
        end
        S_MX2: state <= S_MX2C;
        S_MX2C: begin
          res   <= fdnhr_pkg::sat_sample(fdnhr_pkg::round_shift(mix_acc + prod, 16));
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            mixed_sample <= res;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/fdnhr_ram.sv @@
`timescale 1ns / 1ps
module fdnhr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
